@@ rtl/core/paged_access_splitter_core_macros.svh @@
// Assertion macros shared by the paged access splitter RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef PAGED_ACCESS_SPLITTER_CORE_MACROS_SVH
`define PAGED_ACCESS_SPLITTER_CORE_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold in that cycle.
`define PAS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("paged access splitter check failed");

// Next-cycle implication: when ante holds, cons must hold in the following cycle.
`define PAS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("paged access splitter check failed");

`endif

@@ rtl/core/pas_pkg.sv @@
// Shared types, widths and constants of the paged access splitter.
// Used by every module in rtl/core; depends on nothing else.
`default_nettype none

package pas_pkg;

  // Geometry of the paging scheme.
  localparam int PAGE_BYTES  = 32;
  localparam int TABLE_PAGES = 64;
  localparam int MAX_LENGTH  = 255;

  // Field widths of the transfers.
  localparam int OPCODE_W = 1;
  localparam int PIDX_W   = 6;
  localparam int FRAME_W  = 6;
  localparam int ADDR_W   = 11;
  localparam int LEN_W    = 8;
  localparam int BYTES_W  = 6;

  // Derived widths.
  localparam int OFF_W  = $clog2(PAGE_BYTES);
  localparam int NB_W   = OFF_W + 1;
  localparam int PAGE_W = $clog2(((1 << ADDR_W) + MAX_LENGTH) / PAGE_BYTES + 2);
  localparam int CMP_W  = (LEN_W > NB_W) ? LEN_W : NB_W;

  // Operation codes.
  localparam logic [OPCODE_W-1:0] OP_WRITE     = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_TRANSLATE = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [PIDX_W-1:0]   page_index;
    logic [FRAME_W-1:0]  frame_value;
    logic [ADDR_W-1:0]   logical_address;
    logic [LEN_W-1:0]    access_length;
  } in_t;

  typedef struct packed {
    logic [BYTES_W-1:0] chunk_bytes;
    logic [ADDR_W-1:0]  physical_address;
    logic               fault;
    logic               last_chunk;
  } out_t;

  // Result of one pass of the split unit.
  typedef struct packed {
    logic [NB_W-1:0]  nbytes;
    logic [LEN_W-1:0] rem;
    logic             last;
  } split_res_t;

endpackage

`default_nettype wire

@@ rtl/core/pas_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on pas_pkg for its default geometry.
`default_nettype none

module pas_ram #(
  parameter int WIDTH = pas_pkg::FRAME_W,
  parameter int DEPTH = pas_pkg::TABLE_PAGES
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/core/pas_split_alu.sv @@
// Shared split unit: takes the bytes that fit in the current page off the
// remaining length. Depends on pas_pkg for widths and the result struct.
`default_nettype none

module pas_split_alu (
  input  wire logic [pas_pkg::LEN_W-1:0] rem,
  input  wire logic [pas_pkg::OFF_W-1:0] offset,
  output pas_pkg::split_res_t            res
);

  logic [pas_pkg::CMP_W-1:0] room;
  logic [pas_pkg::CMP_W-1:0] rem_c;
  logic [pas_pkg::CMP_W-1:0] take;

  always_comb begin
    room  = pas_pkg::CMP_W'(pas_pkg::PAGE_BYTES) - pas_pkg::CMP_W'(offset);
    rem_c = pas_pkg::CMP_W'(rem);
    take  = (rem_c < room) ? rem_c : room;
    res.nbytes = pas_pkg::NB_W'(take);
    res.rem    = pas_pkg::LEN_W'(rem_c - take);
    res.last   = (rem_c == take);
  end

endmodule

`default_nettype wire

@@ rtl/core/paged_access_splitter_core.sv @@
// Top level of the paged access splitter: page table, sequencer and output register.
// Depends on pas_pkg, pas_ram, pas_split_alu and the assertion macro header.
`default_nettype none

// Paged access splitter. A write item (opcode 0) stores a frame number for a
// page and marks the page mapped; it produces no result, and busy stays low,
// so another item may follow at the next edge. A translate item (opcode 1)
// is split into one result per page touched, from 1 up to 9 with 32-byte
// pages and lengths saturated to 255. After the accepting edge busy stays
// high while the chunks are computed, and the next item can be taken once
// busy is low again; one chunk per cycle comes from the single shared split
// unit, which is reused for every chunk, while the frame table RAM is read
// one page ahead so its registered read does not delay the chunks. Each
// result appears on out_item for exactly one cycle, flagged by out_strobe,
// in the cycle after the chunk is computed; the receiver cannot stall the
// block, so every transfer on the result side must be captured when it is
// shown. A chunk whose page is not mapped, or lies beyond the table, reports
// fault with a zero physical address but still carries its byte count. The
// mapped flags clear at reset; frame entries need no clearing because an
// entry is only used when its flag is set.

`include "paged_access_splitter_core_macros.svh"

module paged_access_splitter_core #(
  parameter int TABLE_PAGES = pas_pkg::TABLE_PAGES
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire pas_pkg::in_t   in_item,
  output logic                out_strobe,
  output pas_pkg::out_t       out_item
);

  localparam int TAB_AW = $clog2(TABLE_PAGES);
  localparam int EXT_A  = (pas_pkg::PAGE_W > TAB_AW) ? pas_pkg::PAGE_W : TAB_AW;
  // One bit above the widest operand so that the table size itself fits.
  localparam int EXT_W  = ((EXT_A > pas_pkg::PIDX_W) ? EXT_A : pas_pkg::PIDX_W) + 1;

  // Sequencer state and the working registers of the current access.
  pas_pkg::state_t                state_r, state_nxt;
  logic [pas_pkg::PAGE_W-1:0]     page_r, page_nxt;
  logic [pas_pkg::OFF_W-1:0]      off_r, off_nxt;
  logic [pas_pkg::LEN_W-1:0]      rem_r, rem_nxt;
  logic                           mapped_r [TABLE_PAGES];
  logic                           out_valid_r;
  pas_pkg::out_t                  out_r;

  logic                           accept;
  logic                           acc_write;
  logic                           acc_translate;
  logic [EXT_W-1:0]               widx_ext;
  logic                           wr_en;
  logic [EXT_W-1:0]               page_ext;
  logic [EXT_W-1:0]               page_nxt_ext;
  logic [pas_pkg::FRAME_W-1:0]    frame_rd;
  logic                           page_ok;
  logic [pas_pkg::LEN_W-1:0]      len_sat;
  pas_pkg::split_res_t            split;
  pas_pkg::out_t                  chunk;

  // A transfer on the input side completes when start meets a low busy.
  assign accept        = start && !busy;
  assign acc_write     = accept && (in_item.opcode == pas_pkg::OP_WRITE);
  assign acc_translate = accept && (in_item.opcode == pas_pkg::OP_TRANSLATE);

  // Writes to pages past the end of the table are dropped.
  assign widx_ext = EXT_W'(in_item.page_index);
  assign wr_en    = acc_write && (widx_ext < EXT_W'(TABLE_PAGES));

  // Lengths above the limit saturate.
  assign len_sat = (32'(in_item.access_length) > pas_pkg::MAX_LENGTH) ?
                   pas_pkg::LEN_W'(pas_pkg::MAX_LENGTH) : in_item.access_length;

  // The shared split unit works on the current page every chunk cycle.
  pas_split_alu u_split (
    .rem    (rem_r),
    .offset (off_r),
    .res    (split)
  );

  // The RAM is addressed with the page of the next cycle so that the frame
  // of the current page is ready when its chunk is computed.
  assign page_ext     = EXT_W'(page_r);
  assign page_nxt_ext = EXT_W'(page_nxt);

  pas_ram #(
    .WIDTH (pas_pkg::FRAME_W),
    .DEPTH (TABLE_PAGES)
  ) u_frame_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (widx_ext[TAB_AW-1:0]),
    .wdata (in_item.frame_value),
    .raddr (page_nxt_ext[TAB_AW-1:0]),
    .rdata (frame_rd)
  );

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pas_pkg::ST_IDLE: begin
        if (acc_translate) begin
          state_nxt = pas_pkg::ST_EMIT;
        end
      end
      pas_pkg::ST_EMIT: begin
        if (split.last) begin
          state_nxt = pas_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pas_pkg::ST_IDLE;
    endcase
  end

  // Output and datapath logic.
  always_comb begin
    busy     = 1'b0;
    page_nxt = page_r;
    off_nxt  = off_r;
    rem_nxt  = rem_r;
    page_ok  = (page_ext < EXT_W'(TABLE_PAGES)) && mapped_r[page_ext[TAB_AW-1:0]];
    chunk.chunk_bytes      = pas_pkg::BYTES_W'(split.nbytes);
    chunk.physical_address = page_ok ? pas_pkg::ADDR_W'({frame_rd, off_r}) : '0;
    chunk.fault            = !page_ok;
    chunk.last_chunk       = split.last;
    unique case (state_r)
      pas_pkg::ST_IDLE: begin
        if (acc_translate) begin
          page_nxt = pas_pkg::PAGE_W'(in_item.logical_address >> pas_pkg::OFF_W);
          off_nxt  = in_item.logical_address[pas_pkg::OFF_W-1:0];
          rem_nxt  = len_sat;
        end
      end
      pas_pkg::ST_EMIT: begin
        busy     = 1'b1;
        page_nxt = page_r + pas_pkg::PAGE_W'(1);
        off_nxt  = '0;
        rem_nxt  = split.rem;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pas_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      mapped_r    <= '{default: 1'b0};
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == pas_pkg::ST_EMIT);
      if (wr_en) begin
        mapped_r[widx_ext[TAB_AW-1:0]] <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    page_r <= page_nxt;
    off_r  <= off_nxt;
    rem_r  <= rem_nxt;
    if (state_r == pas_pkg::ST_EMIT) begin
      out_r <= chunk;
    end
  end

  assign out_strobe = out_valid_r;
  assign out_item   = out_r;

  // A result only follows a chunk cycle of the sequencer.
  `PAS_ASSERT_NOW(a_strobe_from_emit, out_strobe, $past(state_r == pas_pkg::ST_EMIT))
  // Once the last chunk is shown the block is free again.
  `PAS_ASSERT_NOW(a_last_frees_block, out_strobe && out_item.last_chunk, !busy)
  // A chunk that is not the last is followed directly by another.
  `PAS_ASSERT_NEXT(a_no_gap_in_split, out_strobe && !out_item.last_chunk, out_strobe)
  // A chunk never holds more than one page.
  `PAS_ASSERT_NOW(a_chunk_fits_page, out_strobe,
                  out_item.chunk_bytes <= pas_pkg::BYTES_W'(pas_pkg::PAGE_BYTES))

endmodule

`default_nettype wire
